FILE: rtl/core/vector3_arithmetic_unit_assert.svh
// ----------------------------------------------------------------------------
// Vector unit assertion macros
// Shared assertion forms for the vector unit checkers.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_ARITHMETIC_UNIT_ASSERT_SVH
`define VECTOR3_ARITHMETIC_UNIT_ASSERT_SVH

// checked on every edge outside reset
`define V3AU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define V3AU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/v3au_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector unit package
// Widths, operation codes, pipeline latencies and saturation helper.
// ----------------------------------------------------------------------------
package v3au_pkg;

  localparam int DATA_W        = 32;
  localparam int DEF_FRAC_BITS = 16;
  // wide enough for a sum of three 64-bit products plus rounding
  localparam int SAT_W         = 67;
  // divisor magnitude reaches 2^32 (rounded root), plus sign
  localparam int DEN_W         = 34;
  localparam int SQRT_LAT      = DATA_W + 1;
  localparam int DIV_LAT       = DATA_W + 1;

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_ADDS = 4'd2;
  localparam logic [3:0] OP_SUBS = 4'd3;
  localparam logic [3:0] OP_SCALE = 4'd4;
  localparam logic [3:0] OP_DIVS = 4'd5;
  localparam logic [3:0] OP_DIVV = 4'd6;
  localparam logic [3:0] OP_DOT  = 4'd7;
  localparam logic [3:0] OP_MAG  = 4'd8;
  localparam logic [3:0] OP_NORM = 4'd9;

  typedef logic signed [DATA_W-1:0] q_t;

  localparam q_t Q_MAX = 32'sh7fffffff;
  localparam q_t Q_MIN = 32'sh80000000;

  typedef struct packed {
    logic [3:0]              op;
    logic [2:0][DATA_W-1:0]  x;
    logic [2:0][DATA_W-1:0]  y;
    logic [DATA_W-1:0]       sc;
    logic                    err;
  } sb_t;

  function automatic q_t sat32(input logic signed [SAT_W-1:0] v);
    q_t res;
    if (v > SAT_W'(Q_MAX)) begin
      res = Q_MAX;
    end else if (v < SAT_W'(Q_MIN)) begin
      res = Q_MIN;
    end else begin
      res = v[DATA_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: rtl/core/v3au_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector unit channels
// Operand channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface v3au_in_if;
  import v3au_pkg::*;
  logic       valid;
  logic       ready;
  logic [3:0] opcode;
  q_t         a_x;
  q_t         a_y;
  q_t         a_z;
  q_t         b_x;
  q_t         b_y;
  q_t         b_z;
  q_t         scalar_in;

  modport source (output valid, opcode, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
                  input ready);
  modport sink (input valid, opcode, a_x, a_y, a_z, b_x, b_y, b_z, scalar_in,
                output ready);
endinterface

interface v3au_out_if;
  import v3au_pkg::*;
  logic valid;
  logic ready;
  q_t   r_x;
  q_t   r_y;
  q_t   r_z;
  q_t   scalar_out;
  logic div_error;

  modport source (output valid, r_x, r_y, r_z, scalar_out, div_error, input ready);
  modport sink (input valid, r_x, r_y, r_z, scalar_out, div_error, output ready);
endinterface

FILE: rtl/core/vector3_arithmetic_unit.sv
`timescale 1ns / 1ps
// One item is taken every cycle while the result side keeps up. The depth
// comes from the 33-stage square root, one root bit per stage and then a
// rounding stage, followed by the 33-stage divider, an entry stage, one
// quotient bit per stage and a sign and saturation stage, that every item
// passes through in order; a stalled result holds the whole pipeline, while
// an empty entry stage still takes an item.
// ----------------------------------------------------------------------------
// Three component vector arithmetic unit
// Q fixed point vector ops: add, sub, scalar ops, scale, divide, dot,
// magnitude and normalize, all saturated.
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit #(
  parameter int FRAC_BITS = v3au_pkg::DEF_FRAC_BITS
) (
  input logic          clk,
  input logic          rst,
  v3au_in_if.sink      din,
  v3au_out_if.source   dout
);
  import v3au_pkg::*;

  localparam logic signed [SAT_W-1:0] HALF =
    {{(SAT_W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

  logic en;

  // stage 1: operands
  logic       v1;
  logic [3:0] op1;
  q_t         a1 [3];
  q_t         b1 [3];
  q_t         s1;
  q_t         m1 [3];

  // stage 2: products
  logic                 v2;
  logic [3:0]           op2;
  q_t                   a2 [3];
  q_t                   b2 [3];
  q_t                   s2;
  logic signed [63:0]   p2 [3];

  // stage 3: sums
  logic                    v3;
  logic [3:0]              op3;
  q_t                      a3 [3];
  q_t                      b3 [3];
  q_t                      s3;
  logic signed [SAT_W-1:0] ps3 [3];
  logic signed [SAT_W-1:0] ds3;
  logic [63:0]             sq3;

  // stage 4: direct results
  logic        v4;
  sb_t         sb4;
  sb_t         sb4_next;
  logic [63:0] sq4;

  logic        vq  [SQRT_LAT];
  sb_t         sbq [SQRT_LAT];
  logic [32:0] root;

  sb_t                      sbe;
  logic signed [DEN_W-1:0]  den [3];
  logic        vd  [DIV_LAT];
  sb_t         sbd [DIV_LAT];
  q_t          quo [3];

  logic ov;
  q_t   rx;
  q_t   ry;
  q_t   rz;
  q_t   rsc;
  logic rerr;

  assign en        = !ov || dout.ready;
  assign din.ready = en || !v1;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (op1 == OP_SCALE) begin
        m1[i] = s1;
      end else if (op1 == OP_DOT) begin
        m1[i] = b1[i];
      end else begin
        m1[i] = a1[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (din.ready) begin
      v1 <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.ready) begin
      op1   <= din.opcode;
      a1[0] <= din.a_x;
      a1[1] <= din.a_y;
      a1[2] <= din.a_z;
      b1[0] <= din.b_x;
      b1[1] <= din.b_y;
      b1[2] <= din.b_z;
      s1    <= din.scalar_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2 <= op1;
      s2  <= s1;
      op3 <= op2;
      s3  <= s2;
      for (int i = 0; i < 3; i++) begin
        a2[i]  <= a1[i];
        b2[i]  <= b1[i];
        p2[i]  <= a1[i] * m1[i];
        a3[i]  <= a2[i];
        b3[i]  <= b2[i];
        ps3[i] <= SAT_W'(p2[i]) + HALF;
      end
      ds3 <= SAT_W'(p2[0]) + SAT_W'(p2[1]) + SAT_W'(p2[2]) + HALF;
      sq3 <= 64'(p2[0]) + 64'(p2[1]) + 64'(p2[2]);
      sb4 <= sb4_next;
      sq4 <= sq3;
    end
  end

  always_comb begin
    sb4_next    = '0;
    sb4_next.op = op3;
    unique case (op3)
      OP_ADD: begin
        for (int i = 0; i < 3; i++) sb4_next.x[i] = sat32(SAT_W'(a3[i]) + SAT_W'(b3[i]));
      end
      OP_SUB: begin
        for (int i = 0; i < 3; i++) sb4_next.x[i] = sat32(SAT_W'(a3[i]) - SAT_W'(b3[i]));
      end
      OP_ADDS: begin
        for (int i = 0; i < 3; i++) sb4_next.x[i] = sat32(SAT_W'(a3[i]) + SAT_W'(s3));
      end
      OP_SUBS: begin
        for (int i = 0; i < 3; i++) sb4_next.x[i] = sat32(SAT_W'(a3[i]) - SAT_W'(s3));
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) sb4_next.x[i] = sat32(ps3[i] >>> FRAC_BITS);
      end
      OP_DIVS: begin
        for (int i = 0; i < 3; i++) begin
          sb4_next.x[i] = a3[i];
          sb4_next.y[i] = s3;
        end
        sb4_next.err = (s3 == '0);
      end
      OP_DIVV: begin
        for (int i = 0; i < 3; i++) begin
          sb4_next.x[i] = a3[i];
          sb4_next.y[i] = b3[i];
        end
        sb4_next.err = (b3[0] == '0) || (b3[1] == '0) || (b3[2] == '0);
      end
      OP_DOT: begin
        sb4_next.sc = sat32(ds3 >>> FRAC_BITS);
      end
      OP_MAG: begin
        sb4_next.sc = '0;
      end
      OP_NORM: begin
        for (int i = 0; i < 3; i++) sb4_next.x[i] = a3[i];
      end
      default: begin
        sb4_next.op = op3;
      end
    endcase
  end

  v3au_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (sq4),
    .root (root)
  );

  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_sq_line
    always_ff @(posedge clk) begin
      if (rst) begin
        vq[k] <= 1'b0;
      end else if (en) begin
        vq[k] <= (k == 0) ? v4 : vq[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sbq[k] <= (k == 0) ? sb4 : sbq[(k == 0) ? 0 : k-1];
      end
    end
  end

  // the rounded magnitude joins here: divisor for normalize, result for magnitude
  always_comb begin
    sbe = sbq[SQRT_LAT-1];
    if (sbe.op == OP_NORM) begin
      sbe.err = (root == '0);
    end
    if (sbe.op == OP_MAG) begin
      sbe.sc = (root > 33'(Q_MAX)) ? Q_MAX : root[DATA_W-1:0];
    end
    for (int i = 0; i < 3; i++) begin
      den[i] = (sbe.op == OP_NORM) ? $signed({1'b0, root})
                                   : DEN_W'($signed(sbe.y[i]));
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3au_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk (clk),
      .en  (en),
      .num ($signed(sbe.x[i])),
      .den (den[i]),
      .quo (quo[i])
    );
  end

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_div_line
    always_ff @(posedge clk) begin
      if (rst) begin
        vd[k] <= 1'b0;
      end else if (en) begin
        vd[k] <= (k == 0) ? vq[SQRT_LAT-1] : vd[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sbd[k] <= (k == 0) ? sbe : sbd[(k == 0) ? 0 : k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (en) begin
      ov <= vd[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (sbd[DIV_LAT-1].op == OP_DIVS || sbd[DIV_LAT-1].op == OP_DIVV ||
          sbd[DIV_LAT-1].op == OP_NORM) begin
        rx <= quo[0];
        ry <= quo[1];
        rz <= quo[2];
      end else begin
        rx <= sbd[DIV_LAT-1].x[0];
        ry <= sbd[DIV_LAT-1].x[1];
        rz <= sbd[DIV_LAT-1].x[2];
      end
      rsc  <= sbd[DIV_LAT-1].sc;
      rerr <= sbd[DIV_LAT-1].err;
    end
  end

  assign dout.valid      = ov;
  assign dout.r_x        = rx;
  assign dout.r_y        = ry;
  assign dout.r_z        = rz;
  assign dout.scalar_out = rsc;
  assign dout.div_error  = rerr;

endmodule

FILE: rtl/core/v3au_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined square root
// One root bit per stage over a 64-bit radicand, then round to nearest.
// ----------------------------------------------------------------------------
module v3au_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [32:0] root
);
  import v3au_pkg::*;

  localparam int STEPS = SQRT_LAT - 1;

  logic [32:0] rem_q [STEPS];
  logic [31:0] rt_q  [STEPS];
  logic [63:0] x_q   [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [32:0] rem_i;
    logic [31:0] rt_i;
    logic [63:0] x_i;
    logic [34:0] rem2;
    logic [34:0] trial;

    if (k == 0) begin : g_first
      assign rem_i = '0;
      assign rt_i  = '0;
      assign x_i   = rad;
    end else begin : g_next
      assign rem_i = rem_q[k-1];
      assign rt_i  = rt_q[k-1];
      assign x_i   = x_q[k-1];
    end

    assign rem2  = {rem_i, x_i[63:62]};
    assign trial = {1'b0, rt_i, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        x_q[k] <= {x_i[61:0], 2'b00};
        if (rem2 >= trial) begin
          rem_q[k] <= 33'(rem2 - trial);
          rt_q[k]  <= {rt_i[30:0], 1'b1};
        end else begin
          rem_q[k] <= rem2[32:0];
          rt_q[k]  <= {rt_i[30:0], 1'b0};
        end
      end
    end
  end

  // round up when the remainder exceeds the floor root
  always_ff @(posedge clk) begin
    if (en) begin
      root <= {1'b0, rt_q[STEPS-1]} +
              33'(rem_q[STEPS-1] > {1'b0, rt_q[STEPS-1]});
    end
  end

endmodule

FILE: rtl/core/v3au_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined fixed point divider
// Restoring division of num * 2^FRAC_BITS by den, truncated, saturated.
// ----------------------------------------------------------------------------
module v3au_div #(
  parameter int FRAC_BITS = v3au_pkg::DEF_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  v3au_pkg::q_t                         num,
  input  logic signed [v3au_pkg::DEN_W-1:0]    den,
  output v3au_pkg::q_t                         quo
);
  import v3au_pkg::*;

  localparam int NUM_W = DATA_W + FRAC_BITS;
  localparam int QB    = DATA_W - 1;
  localparam int MAG_W = DEN_W - 1;

  logic [DATA_W-1:0]   nmag;
  logic [DEN_W-1:0]    dneg;
  logic [MAG_W-1:0]    dmag;
  logic [NUM_W-1:0]    nfull;
  logic [NUM_W-QB-1:0] ntop;

  logic [MAG_W-1:0] r_q   [QB+1];
  logic [MAG_W-1:0] d_q   [QB+1];
  logic [QB-1:0]    lo_q  [QB+1];
  logic [QB-1:0]    q_q   [QB+1];
  logic             ovf_q [QB+1];
  logic             neg_q [QB+1];

  always_comb begin
    nmag  = num[DATA_W-1] ? (~num + 1'b1) : num;
    dneg  = ~den + 1'b1;
    dmag  = den[DEN_W-1] ? dneg[MAG_W-1:0] : den[MAG_W-1:0];
    nfull = {nmag, {FRAC_BITS{1'b0}}};
    ntop  = nfull[NUM_W-1:QB];
  end

  // a quotient of 2^31 or more saturates either way; zero divisor lands here too
  always_ff @(posedge clk) begin
    if (en) begin
      r_q[0]   <= MAG_W'(ntop);
      d_q[0]   <= dmag;
      lo_q[0]  <= nfull[QB-1:0];
      q_q[0]   <= '0;
      ovf_q[0] <= (MAG_W'(ntop) >= dmag);
      neg_q[0] <= num[DATA_W-1] ^ den[DEN_W-1];
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_iter
    logic [MAG_W:0] r2;
    logic [MAG_W:0] dext;
    logic           ge;

    assign r2   = {r_q[k-1], lo_q[k-1][QB-1]};
    assign dext = {1'b0, d_q[k-1]};
    assign ge   = (r2 >= dext);

    always_ff @(posedge clk) begin
      if (en) begin
        r_q[k]   <= ge ? MAG_W'(r2 - dext) : r2[MAG_W-1:0];
        d_q[k]   <= d_q[k-1];
        lo_q[k]  <= {lo_q[k-1][QB-2:0], 1'b0};
        q_q[k]   <= {q_q[k-1][QB-2:0], ge};
        ovf_q[k] <= ovf_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ovf_q[QB]) begin
        quo <= neg_q[QB] ? Q_MIN : Q_MAX;
      end else if (neg_q[QB]) begin
        quo <= -$signed({1'b0, q_q[QB]});
      end else begin
        quo <= $signed({1'b0, q_q[QB]});
      end
    end
  end

endmodule

FILE: rtl/core/v3au_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector unit port checker
// Watches the channel ports of the vector unit over time.
// ----------------------------------------------------------------------------
`include "vector3_arithmetic_unit_assert.svh"

module v3au_chk (
  input logic         clk,
  input logic         rst,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input v3au_pkg::q_t r_x,
  input v3au_pkg::q_t r_y,
  input v3au_pkg::q_t r_z,
  input v3au_pkg::q_t scalar_out,
  input logic         div_error
);
  import v3au_pkg::*;

  logic any_sat;

  assign any_sat = (r_x == Q_MAX) || (r_x == Q_MIN) || (r_y == Q_MAX) ||
                   (r_y == Q_MIN) || (r_z == Q_MAX) || (r_z == Q_MIN);

  `V3AU_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped while stalled")
  `V3AU_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(r_x) && $stable(r_y) && $stable(r_z) && $stable(scalar_out) && $stable(div_error), "result beat changed while stalled")
  `V3AU_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "result beat right after reset")
  `V3AU_ASSERT(a_ready_stall, !in_ready |-> out_valid && !out_ready, "input held off without an output stall")
  `V3AU_ASSERT(a_err_sat, out_valid && div_error |-> any_sat && scalar_out == '0, "divide error without a saturated component")

endmodule

bind vector3_arithmetic_unit v3au_chk u_v3au_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (din.valid),
  .in_ready   (din.ready),
  .out_valid  (dout.valid),
  .out_ready  (dout.ready),
  .r_x        (dout.r_x),
  .r_y        (dout.r_y),
  .r_z        (dout.r_z),
  .scalar_out (dout.scalar_out),
  .div_error  (dout.div_error)
);
